FILE: rtl/core/iia_pkg.sv
// shared types and constants of the interval id allocator
`timescale 1ns / 1ps

package iia_pkg;

  localparam int IdW = 32;
  localparam int StatusW = 2;
  localparam int MaxEntriesW = 11;

  localparam logic [IdW-1:0] U32_MAX = '1;

  // function codes
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // status codes
  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [StatusW-1:0] ST_LEAKED    = 2'd2;
  localparam logic [StatusW-1:0] ST_NOT_ALLOC = 2'd3;

  // results of the shared compare and step unit
  typedef struct packed {
    logic           lt;
    logic           eq;
    logic           inc_eq;
    logic [IdW-1:0] a_inc;
    logic [IdW-1:0] b_dec;
  } alu_res_t;

endpackage

FILE: rtl/core/iia_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module iia_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/iia_alu.sv
// shared compare, increment and decrement unit of the allocator
`timescale 1ns / 1ps

module iia_alu (
  input  logic [iia_pkg::IdW-1:0] a,
  input  logic [iia_pkg::IdW-1:0] b,
  output iia_pkg::alu_res_t       res
);

  import iia_pkg::*;

  logic [IdW-1:0] a_inc;

  assign a_inc = a + IdW'(1);

  // unsigned compares and the one-step neighbors of the operands
  always_comb begin
    res.lt     = (a < b);
    res.eq     = (a == b);
    res.inc_eq = (a_inc == b);
    res.a_inc  = a_inc;
    res.b_dec  = b - IdW'(1);
  end

endmodule

FILE: rtl/core/interval_id_allocator.sv
// top level of the interval id allocator: sequencer, boundary list and entry count
`timescale 1ns / 1ps

// Hands out and takes back 32-bit ids, tracked as a sorted list of run
// boundaries in one ram (even entries start used runs, odd entries start
// free runs). A word is taken when start is high and busy is low; busy stays
// high until the result word is shown on out_* with out_strobe for exactly
// one cycle, and the receiver cannot stall it. All list traffic goes through
// the single ram with at most one read and one write per cycle, so latency is
// set by the list walk. Allocate reads the first free run and, when that run
// empties, moves the entries above it down; release searches the list pair by
// pair and moves entries on a merge or split. After reset the block writes
// the initial boundaries with busy high. The user may change the limit
// through cfg_wdata only while busy is low; the block does not enforce this.

module interval_id_allocator #(
  parameter int MAP_ENTRIES = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_func,
  input  logic [iia_pkg::IdW-1:0]          in_object_id,
  output logic                             out_strobe,
  output logic [iia_pkg::IdW-1:0]          out_allocated_id,
  output logic [iia_pkg::StatusW-1:0]      out_status,
  input  logic                             cfg_we,
  input  logic [iia_pkg::MaxEntriesW-1:0]  cfg_wdata
);

  import iia_pkg::*;

  localparam int AW = $clog2(MAP_ENTRIES);
  localparam int CW = $clog2(MAP_ENTRIES + 1);
  localparam int LW = (CW > MaxEntriesW) ? CW : MaxEntriesW;
  localparam int ListCap = MAP_ENTRIES - (MAP_ENTRIES % 2);

  // sequencer states
  localparam logic [3:0] S_INIT0    = 4'd0;
  localparam logic [3:0] S_INIT1    = 4'd1;
  localparam logic [3:0] S_IDLE     = 4'd2;
  localparam logic [3:0] S_AL_FIRST = 4'd3;
  localparam logic [3:0] S_AL_NEXT  = 4'd4;
  localparam logic [3:0] S_RL_SCAN  = 4'd5;
  localparam logic [3:0] S_RL_LO    = 4'd6;
  localparam logic [3:0] S_RL_HI    = 4'd7;
  localparam logic [3:0] S_SD_RD    = 4'd8;
  localparam logic [3:0] S_SD_WR    = 4'd9;
  localparam logic [3:0] S_SU_RD    = 4'd10;
  localparam logic [3:0] S_SU_WR    = 4'd11;
  localparam logic [3:0] S_SU_FIN   = 4'd12;

  logic [3:0]             state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [MaxEntriesW-1:0] maxe_r, maxe_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  logic [IdW-1:0]         out_id_r, out_id_nxt;
  logic [StatusW-1:0]     out_status_r, out_status_nxt;
  logic [IdW-1:0]         id_r, id_nxt;
  logic [IdW-1:0]         got_r, got_nxt;
  logic [CW-1:0]          i_r, i_nxt;
  logic [CW-1:0]          k_r, k_nxt;
  logic                   lt_lo_r, lt_lo_nxt;
  logic                   eq_lo_r, eq_lo_nxt;

  logic                   ram_we;
  logic [CW-1:0]          ram_wa;
  logic [IdW-1:0]         ram_wdata;
  logic [CW-1:0]          ram_ra;
  logic [IdW-1:0]         ram_rdata;

  logic [IdW-1:0]         alu_a, alu_b;
  alu_res_t               alu_res;

  logic [CW-1:0]          i_p1, i_p2, k_p1, k_p2, k_m1, cnt_p2, cnt_m2;
  logic [LW-1:0]          lim_even, lim_capped, lim;

  // boundary list storage
  iia_ram #(
    .Width (IdW),
    .Depth (MAP_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_ra[AW-1:0]),
    .rdata (ram_rdata)
  );

  // shared compare and step unit, operands picked by state
  assign alu_a = (state_r == S_AL_FIRST) ? ram_rdata :
                 (state_r == S_AL_NEXT)  ? got_r : id_r;
  assign alu_b = (state_r == S_AL_FIRST) ? U32_MAX : ram_rdata;

  iia_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // index neighbors
  assign i_p1   = i_r + CW'(1);
  assign i_p2   = i_r + CW'(2);
  assign k_p1   = k_r + CW'(1);
  assign k_p2   = k_r + CW'(2);
  assign k_m1   = k_r - CW'(1);
  assign cnt_p2 = cnt_r + CW'(2);
  assign cnt_m2 = cnt_r - CW'(2);

  // effective entry limit: even, capped at the list size, at least two
  always_comb begin
    lim_even   = LW'(maxe_r) & ~LW'(1);
    lim_capped = (lim_even > LW'(ListCap)) ? LW'(ListCap) : lim_even;
    lim        = (lim_capped < LW'(2)) ? LW'(2) : lim_capped;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    maxe_nxt       = cfg_we ? cfg_wdata : maxe_r;
    out_strobe_nxt = 1'b0;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    id_nxt         = id_r;
    got_nxt        = got_r;
    i_nxt          = i_r;
    k_nxt          = k_r;
    lt_lo_nxt      = lt_lo_r;
    eq_lo_nxt      = eq_lo_r;
    ram_we         = 1'b0;
    ram_wa         = i_r;
    ram_wdata      = alu_res.a_inc;
    ram_ra         = i_r;

    case (state_r)
      S_INIT0: begin
        ram_we    = 1'b1;
        ram_wa    = CW'(0);
        ram_wdata = IdW'(1);
        state_nxt = S_INIT1;
      end
      S_INIT1: begin
        ram_we    = 1'b1;
        ram_wa    = CW'(1);
        ram_wdata = IdW'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          id_nxt = in_object_id;
          if (in_func == FUNC_ALLOC) begin
            ram_ra    = CW'(1);
            state_nxt = S_AL_FIRST;
          end else begin
            got_nxt   = '0;
            i_nxt     = '0;
            state_nxt = S_RL_SCAN;
          end
        end
      end
      S_AL_FIRST: begin
        // first free id is in the read data
        if (alu_res.eq) begin
          out_strobe_nxt = 1'b1;
          out_id_nxt     = '0;
          out_status_nxt = ST_EXHAUSTED;
          state_nxt      = S_IDLE;
        end else begin
          got_nxt   = ram_rdata;
          ram_we    = 1'b1;
          ram_wa    = CW'(1);
          ram_wdata = alu_res.a_inc;
          if (cnt_r > CW'(2)) begin
            ram_ra    = CW'(2);
            state_nxt = S_AL_NEXT;
          end else begin
            out_strobe_nxt = 1'b1;
            out_id_nxt     = ram_rdata;
            out_status_nxt = ST_OK;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_AL_NEXT: begin
        // free run emptied: drop entries 1 and 2
        if (alu_res.inc_eq) begin
          k_nxt     = CW'(1);
          state_nxt = S_SD_RD;
        end else begin
          out_strobe_nxt = 1'b1;
          out_id_nxt     = got_r;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      S_RL_SCAN: begin
        if (i_p1 < cnt_r) begin
          ram_ra    = i_r;
          state_nxt = S_RL_LO;
        end else begin
          out_strobe_nxt = 1'b1;
          out_id_nxt     = '0;
          out_status_nxt = ST_NOT_ALLOC;
          state_nxt      = S_IDLE;
        end
      end
      S_RL_LO: begin
        lt_lo_nxt = alu_res.lt;
        eq_lo_nxt = alu_res.eq;
        ram_ra    = i_p1;
        state_nxt = S_RL_HI;
      end
      S_RL_HI: begin
        if (lt_lo_r || !alu_res.lt) begin
          // id outside this used run
          i_nxt     = i_p2;
          state_nxt = S_RL_SCAN;
        end else if (eq_lo_r) begin
          // grow the run start
          ram_we    = 1'b1;
          ram_wa    = i_r;
          ram_wdata = alu_res.a_inc;
          if (alu_res.inc_eq && (cnt_r > CW'(2))) begin
            k_nxt     = i_r;
            state_nxt = S_SD_RD;
          end else begin
            out_strobe_nxt = 1'b1;
            out_id_nxt     = '0;
            out_status_nxt = ST_OK;
            state_nxt      = S_IDLE;
          end
        end else if (alu_res.inc_eq) begin
          // last id of the run: pull the run end down
          ram_we         = 1'b1;
          ram_wa         = i_p1;
          ram_wdata      = alu_res.b_dec;
          out_strobe_nxt = 1'b1;
          out_id_nxt     = '0;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end else if (LW'(cnt_r) >= lim) begin
          out_strobe_nxt = 1'b1;
          out_id_nxt     = '0;
          out_status_nxt = ST_LEAKED;
          state_nxt      = S_IDLE;
        end else begin
          k_nxt     = cnt_r;
          state_nxt = S_SU_RD;
        end
      end
      S_SD_RD: begin
        // shift entries down by two
        if (k_p2 < cnt_r) begin
          ram_ra    = k_p2;
          state_nxt = S_SD_WR;
        end else begin
          cnt_nxt        = cnt_m2;
          out_strobe_nxt = 1'b1;
          out_id_nxt     = got_r;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      S_SD_WR: begin
        ram_we    = 1'b1;
        ram_wa    = k_r;
        ram_wdata = ram_rdata;
        k_nxt     = k_p1;
        state_nxt = S_SD_RD;
      end
      S_SU_RD: begin
        // shift entries up by two, from the top
        if (k_r > i_p1) begin
          ram_ra    = k_m1;
          state_nxt = S_SU_WR;
        end else begin
          ram_we    = 1'b1;
          ram_wa    = i_p1;
          ram_wdata = id_r;
          state_nxt = S_SU_FIN;
        end
      end
      S_SU_WR: begin
        ram_we    = 1'b1;
        ram_wa    = k_p1;
        ram_wdata = ram_rdata;
        k_nxt     = k_m1;
        state_nxt = S_SU_RD;
      end
      S_SU_FIN: begin
        ram_we         = 1'b1;
        ram_wa         = i_p2;
        ram_wdata      = alu_res.a_inc;
        cnt_nxt        = cnt_p2;
        out_strobe_nxt = 1'b1;
        out_id_nxt     = '0;
        out_status_nxt = ST_OK;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT0;
      cnt_r        <= CW'(2);
      maxe_r       <= MaxEntriesW'(1024);
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      maxe_r       <= maxe_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
    id_r         <= id_nxt;
    got_r        <= got_nxt;
    i_r          <= i_nxt;
    k_r          <= k_nxt;
    lt_lo_r      <= lt_lo_nxt;
    eq_lo_r      <= eq_lo_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_allocated_id = out_id_r;
  assign out_status       = out_status_r;

endmodule

FILE: rtl/core/iia_checker.sv
// port level checks of the interval id allocator and their bind
`timescale 1ns / 1ps

module iia_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_strobe,
  input logic [iia_pkg::IdW-1:0]         out_allocated_id,
  input logic [iia_pkg::StatusW-1:0]     out_status
);

  import iia_pkg::*;

  // reset starts the boundary init pass with no result pending
  a_reset_init: assert property (@(posedge clk)
    !rst_n |=> busy && !out_strobe)
    else $error("no init pass after reset");

  // an accepted word keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy && !out_strobe)
    else $error("accepted word did not make the block busy");

  // one result per word, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // only a good allocate hands out an id
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ST_OK)) |-> (out_allocated_id == '0))
    else $error("nonzero id with failing status");

endmodule

bind interval_id_allocator iia_checker u_iia_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_allocated_id (out_allocated_id),
  .out_status       (out_status)
);

FILE: sim/tb_interval_id_allocator.sv
// testbench of the interval id allocator: directed table and random words against a predictor
`timescale 1ns / 1ps

module tb_interval_id_allocator;
  import iia_pkg::*;

  localparam int MapEntries = 1024;
  localparam int ListCap = MapEntries & ~1;
  // slowest release walks and shifts the whole list
  localparam int StallLimit = 40000;
  localparam int NumDir = 26;
  localparam int NumPhases = 8;

  typedef struct packed {
    logic           func;
    logic [IdW-1:0] id;
  } id_word_t;

  typedef struct packed {
    logic [IdW-1:0]     allocated_id;
    logic [StatusW-1:0] status;
  } id_result_t;

  typedef enum logic {ROW_WORD, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic                   func;
    logic [IdW-1:0]         id;
    logic [MaxEntriesW-1:0] limit;
    logic                   typed;
    logic [IdW-1:0]         want_id;
    logic [StatusW-1:0]     want_st;
  } dir_row_t;

  // directed words; list contents after each row noted on the right
  localparam dir_row_t DirRows [NumDir] = '{
    '{ROW_WORD,  FUNC_RELEASE, 32'd1,  11'd0, 1'b1, 32'd0, ST_NOT_ALLOC}, // empty run [1,1]
    '{ROW_WORD,  FUNC_ALLOC,   32'd0,  11'd0, 1'b1, 32'd1, ST_OK},        // [1,2]
    '{ROW_WORD,  FUNC_ALLOC,   32'd0,  11'd0, 1'b0, 32'd0, ST_OK},        // [1,3]
    '{ROW_WORD,  FUNC_ALLOC,   32'd0,  11'd0, 1'b0, 32'd0, ST_OK},        // [1,4]
    '{ROW_WORD,  FUNC_ALLOC,   32'd0,  11'd0, 1'b0, 32'd0, ST_OK},        // [1,5]
    '{ROW_WORD,  FUNC_RELEASE, 32'd0,  11'd0, 1'b1, 32'd0, ST_NOT_ALLOC}, // below first run
    '{ROW_WORD,  FUNC_RELEASE, U32_MAX, 11'd0, 1'b1, 32'd0, ST_NOT_ALLOC},
    '{ROW_WORD,  FUNC_RELEASE, 32'd5,  11'd0, 1'b0, 32'd0, ST_OK},        // free id
    '{ROW_WORD,  FUNC_RELEASE, 32'd3,  11'd0, 1'b0, 32'd0, ST_OK},        // split [1,3,4,5]
    '{ROW_WORD,  FUNC_RELEASE, 32'd3,  11'd0, 1'b0, 32'd0, ST_OK},        // already free
    '{ROW_WORD,  FUNC_RELEASE, 32'd4,  11'd0, 1'b0, 32'd0, ST_OK},        // run empties [1,3]
    '{ROW_WORD,  FUNC_RELEASE, 32'd2,  11'd0, 1'b0, 32'd0, ST_OK},        // run end [1,2]
    '{ROW_WORD,  FUNC_ALLOC,   32'd0,  11'd0, 1'b0, 32'd0, ST_OK},        // [1,3]
    '{ROW_WORD,  FUNC_ALLOC,   32'd0,  11'd0, 1'b0, 32'd0, ST_OK},        // [1,4]
    '{ROW_WORD,  FUNC_RELEASE, 32'd1,  11'd0, 1'b0, 32'd0, ST_OK},        // [2,4]
    '{ROW_WORD,  FUNC_RELEASE, 32'd2,  11'd0, 1'b0, 32'd0, ST_OK},        // [3,4]
    '{ROW_WORD,  FUNC_RELEASE, 32'd3,  11'd0, 1'b0, 32'd0, ST_OK},        // only pair kept [4,4]
    '{ROW_WORD,  FUNC_ALLOC,   32'd0,  11'd0, 1'b0, 32'd0, ST_OK},        // [4,5]
    '{ROW_WORD,  FUNC_ALLOC,   32'd0,  11'd0, 1'b0, 32'd0, ST_OK},        // [4,6]
    '{ROW_WORD,  FUNC_ALLOC,   32'd0,  11'd0, 1'b0, 32'd0, ST_OK},        // [4,7]
    '{ROW_WORD,  FUNC_RELEASE, 32'd5,  11'd0, 1'b0, 32'd0, ST_OK},        // split [4,5,6,7]
    '{ROW_WORD,  FUNC_ALLOC,   32'd0,  11'd0, 1'b0, 32'd0, ST_OK},        // free run closes [4,7]
    '{ROW_LIMIT, FUNC_ALLOC,   32'd0,  11'd2, 1'b0, 32'd0, ST_OK},
    '{ROW_WORD,  FUNC_RELEASE, 32'd5,  11'd0, 1'b1, 32'd0, ST_LEAKED},    // split with list full
    '{ROW_WORD,  FUNC_RELEASE, 32'd6,  11'd0, 1'b0, 32'd0, ST_OK},        // [4,6]
    '{ROW_WORD,  FUNC_ALLOC,   U32_MAX, 11'd0, 1'b0, 32'd0, ST_OK}        // id bits ignored
  };

  // random phases: limit setting, sender idle percent, words
  localparam int PhaseLimit [NumPhases] = '{0, 2047, 3, 6, 17, 64, 1024, 2};
  localparam int PhaseIdle  [NumPhases] = '{0, 52, 38, 0, 52, 38, 0, 52};
  localparam int PhaseWords [NumPhases] = '{60, 120, 50, 70, 80, 90, 60, 50};

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic                   in_func;
  logic [IdW-1:0]         in_object_id;
  logic                   out_strobe;
  logic [IdW-1:0]         out_allocated_id;
  logic [StatusW-1:0]     out_status;
  logic                   cfg_we;
  logic [MaxEntriesW-1:0] cfg_wdata;

  // predicted allocator state
  logic [IdW-1:0]         runs [MapEntries];
  int                     run_cnt;
  int                     peak_cnt;
  logic [MaxEntriesW-1:0] limit_reg;
  id_result_t             results_due [$];

  int fail_cnt = 0;
  int words_sent = 0;
  int results_seen = 0;
  int limit_writes = 0;
  int idle_pct = 0;
  int stall_cnt = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  interval_id_allocator #(
    .MAP_ENTRIES(MapEntries)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_object_id    (in_object_id),
    .out_strobe      (out_strobe),
    .out_allocated_id(out_allocated_id),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  // remove boundaries pos and pos+1
  function automatic void drop_pair(input int pos);
    for (int k = pos; k + 2 < run_cnt; k++) runs[k] = runs[k + 2];
    run_cnt -= 2;
  endfunction

  // apply one word to the predicted list and return its result
  function automatic id_result_t apply_word(input logic func, input logic [IdW-1:0] id);
    id_result_t     r;
    logic [IdW-1:0] lo;
    logic [IdW-1:0] hi;
    int             lim;
    r.allocated_id = '0;
    r.status = ST_NOT_ALLOC;
    lim = int'(limit_reg) & ~1;
    if (lim > ListCap) lim = ListCap;
    if (lim < 2) lim = 2;
    if (func == FUNC_ALLOC) begin
      if (runs[1] == U32_MAX) begin
        r.status = ST_EXHAUSTED;
      end else begin
        r.allocated_id = runs[1];
        r.status = ST_OK;
        runs[1] = runs[1] + 1;
        if (run_cnt > 2 && runs[1] == runs[2]) drop_pair(1);
      end
    end else begin
      // find the used run that holds the id
      for (int p = 0; p + 1 < run_cnt; p += 2) begin
        lo = runs[p];
        hi = runs[p + 1];
        if (id >= lo && id < hi) begin
          if (id == lo) begin
            runs[p] = lo + 1;
            if (runs[p] == hi && run_cnt > 2) drop_pair(p);
            r.status = ST_OK;
          end else if (id + 32'd1 == hi) begin
            runs[p + 1] = hi - 1;
            r.status = ST_OK;
          end else if (run_cnt >= lim || run_cnt + 2 > ListCap) begin
            r.status = ST_LEAKED;
          end else begin
            for (int k = run_cnt; k > p + 1; k--) runs[k + 1] = runs[k - 1];
            runs[p + 1] = id;
            runs[p + 2] = id + 1;
            run_cnt += 2;
            if (run_cnt > peak_cnt) peak_cnt = run_cnt;
            r.status = ST_OK;
          end
          break;
        end
      end
    end
    return r;
  endfunction

  // mostly allocates and releases of held ids, some stray ids
  function automatic id_word_t pick_word();
    id_word_t       w;
    int             p;
    int             r;
    logic [IdW-1:0] lo;
    logic [IdW-1:0] hi;
    r = $urandom_range(99);
    p = 2 * $urandom_range(run_cnt / 2 - 1);
    lo = runs[p];
    hi = runs[p + 1];
    w.func = FUNC_RELEASE;
    w.id = $urandom;
    if (r < 45) begin
      w.func = FUNC_ALLOC;
    end else if (r < 85) begin
      case ($urandom_range(2))
        0: w.id = lo;
        1: w.id = hi - 1;
        default: w.id = (hi > lo + 1) ? lo + $urandom_range(hi - lo - 1) : lo;
      endcase
    end else begin
      case ($urandom_range(3))
        0: w.id = hi;
        1: w.id = runs[run_cnt - 1] + $urandom_range(3);
        2: w.id = $urandom_range(1) ? U32_MAX : '0;
        default: ;
      endcase
    end
    return w;
  endfunction

  // present one word, hold it until taken, then queue its result
  task automatic send_word(input id_word_t w, input bit typed, input id_result_t want);
    id_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_func      <= w.func;
    in_object_id <= w.id;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_word(w.func, w.id);
    results_due.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  // change the entry limit once the block has drained
  task automatic write_limit(input logic [MaxEntriesW-1:0] value);
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy !== 1'b0);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    limit_reg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_writes++;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stimulus
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_ALLOC;
    in_object_id = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    runs[0] = 32'd1;
    runs[1] = 32'd1;
    run_cnt = 2;
    peak_cnt = 2;
    limit_reg = 11'd1024;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < NumDir; r++) begin
      if (DirRows[r].kind == ROW_LIMIT) begin
        write_limit(DirRows[r].limit);
      end else begin
        send_word(id_word_t'{DirRows[r].func, DirRows[r].id}, DirRows[r].typed,
                  id_result_t'{DirRows[r].want_id, DirRows[r].want_st});
      end
    end
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_limit(MaxEntriesW'(PhaseLimit[ph]));
      idle_pct = PhaseIdle[ph];
      repeat (PhaseWords[ph]) send_word(pick_word(), 1'b0, '0);
    end
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("%0d words sent over %0d limit settings, %0d results checked, longest list %0d",
             words_sent, limit_writes, results_seen, peak_cnt);
    $display("statuses: ok %0d, exhausted %0d, leaked %0d, not allocated %0d",
             status_seen[ST_OK], status_seen[ST_EXHAUSTED], status_seen[ST_LEAKED],
             status_seen[ST_NOT_ALLOC]);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // compare each result word with the oldest outstanding one
  always @(posedge clk) begin : check_results
    id_result_t due;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      results_seen++;
      if (results_due.size() == 0) begin
        $error("result word with none outstanding: id %0h status %0d",
               out_allocated_id, out_status);
        fail_cnt++;
      end else begin
        due = results_due.pop_front();
        status_seen[due.status]++;
        if (out_allocated_id !== due.allocated_id) begin
          $error("allocated_id: expected %0h, got %0h", due.allocated_id, out_allocated_id);
          fail_cnt++;
        end
        if (out_status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, out_status);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $error("no word moved for %0d cycles", StallLimit);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

endmodule
